>>> hw/rtl/cubic_bezier_point_eval_top_assert.svh
// Assertion macros for the RTL (included by cbez_queue).
`ifndef CUBIC_BEZIER_POINT_EVAL_TOP_ASSERT_SVH
`define CUBIC_BEZIER_POINT_EVAL_TOP_ASSERT_SVH

// Same-cycle implication.
`define CBEZ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define CBEZ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/cbez_pkg.sv
package cbez_pkg;

	localparam int COORD_BITS  = 20;
	localparam int TIME_BITS   = 16;
	localparam int Q_BITS      = 16;
	localparam int U_BITS      = Q_BITS + 1;
	localparam int SQ_BITS     = 2 * U_BITS;
	localparam int CUBE_BITS   = 3 * U_BITS;
	localparam int W_BITS      = 33;
	localparam int PROD_BITS   = W_BITS + 1 + COORD_BITS;
	localparam int SUM_BITS    = PROD_BITS + 2;
	localparam int FRAC_DROP   = 32;
	localparam int RQ_BITS     = SUM_BITS - FRAC_DROP;
	localparam int NUM_REGS    = 8;
	localparam int REG_BITS    = 60;
	localparam int IDX_BITS    = 4;
	localparam int SEL_BITS    = $clog2(NUM_REGS);
	localparam int NUM_AXES    = 3;
	localparam int NUM_OUTS    = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = QPTR_BITS + 1;

	typedef logic [U_BITS-1:0] u_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [REG_BITS-1:0] reg_t;

	localparam u_t U_ONE = u_t'(1) << Q_BITS;

	function automatic coord_t coord_of(input reg_t r, input int axis);
		coord_t c;
		c = coord_t'(r[axis*COORD_BITS +: COORD_BITS]);
		return c;
	endfunction

endpackage

>>> hw/rtl/cbez_front.sv
module cbez_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [cbez_pkg::TIME_BITS-1:0]       elapsed,
	input  logic [cbez_pkg::TIME_BITS-1:0]       span,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output cbez_pkg::u_t                         u
);

	localparam int TB = cbez_pkg::TIME_BITS;
	localparam int QB = cbez_pkg::Q_BITS;
	localparam int LAST = QB;

	logic          vld_q [LAST+1];
	logic [TB-1:0] rem_q [LAST+1];
	logic [TB-1:0] div_q [LAST+1];
	logic [QB-1:0] quo_q [LAST+1];
	logic          sat_q [LAST+1];

	logic [TB:0]   shl   [LAST+1];
	logic [TB:0]   dif   [LAST+1];
	logic          ge    [LAST+1];
	logic          adv;

	always_comb begin
		adv = !vld_q[LAST] || out_ready;
		in_ready = adv;
		out_valid = vld_q[LAST];
		u = sat_q[LAST] ? cbez_pkg::U_ONE : {1'b0, quo_q[LAST]};
	end

	always_comb begin
		shl[0] = '0;
		dif[0] = '0;
		ge[0] = 1'b0;
		for (int k = 1; k <= LAST; k++) begin
			shl[k] = {rem_q[k-1], 1'b0};
			dif[k] = shl[k] - {1'b0, div_q[k-1]};
			ge[k] = shl[k] >= {1'b0, div_q[k-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LAST; k++)
				vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k <= LAST; k++)
				vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q[0] <= elapsed;
			div_q[0] <= span;
			quo_q[0] <= '0;
			sat_q[0] <= (span == '0) || (elapsed >= span);
			for (int k = 1; k <= LAST; k++) begin
				div_q[k] <= div_q[k-1];
				sat_q[k] <= sat_q[k-1];
				rem_q[k] <= ge[k] ? dif[k][TB-1:0] : shl[k][TB-1:0];
				quo_q[k] <= {quo_q[k-1][QB-2:0], ge[k]};
			end
		end
	end

endmodule

>>> hw/rtl/cbez_queue.sv
module cbez_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  cbez_pkg::u_t push_u,
	output logic         pop_valid,
	input  logic         pop_ready,
	output cbez_pkg::u_t pop_u
);

	localparam int PB = cbez_pkg::QPTR_BITS;
	localparam int CB = cbez_pkg::QCNT_BITS;
	localparam logic [CB-1:0] FULL_CNT = CB'(cbez_pkg::QUEUE_DEPTH);
	localparam logic [CB-1:0] ONE_CNT = CB'(1);
	localparam logic [PB-1:0] ONE_PTR = PB'(1);

	cbez_pkg::u_t  mem_q [cbez_pkg::QUEUE_DEPTH];
	logic [PB-1:0] wr_q;
	logic [PB-1:0] rd_q;
	logic [CB-1:0] cnt_q;
	logic          push;
	logic          pop;

	always_comb begin
		push_ready = cnt_q != FULL_CNT;
		pop_valid = cnt_q != '0;
		pop_u = mem_q[rd_q];
		push = push_valid && push_ready;
		pop = pop_valid && pop_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + ONE_PTR;
			if (pop)
				rd_q <= rd_q + ONE_PTR;
			if (push && !pop)
				cnt_q <= cnt_q + ONE_CNT;
			else if (pop && !push)
				cnt_q <= cnt_q - ONE_CNT;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_u;
	end

`include "cubic_bezier_point_eval_top_assert.svh"

	`CBEZ_ASSERT_IMP(a_pop_nonempty, pop, cnt_q != '0)
	`CBEZ_ASSERT_NXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + ONE_CNT)
	`CBEZ_ASSERT_NXT(a_cnt_down, pop && !push, cnt_q == $past(cnt_q) - ONE_CNT)

endmodule

>>> hw/rtl/cbez_back.sv
module cbez_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cbez_pkg::u_t     u,
	input  cbez_pkg::reg_t   ctrl [cbez_pkg::NUM_REGS],
	output logic             out_valid,
	input  logic             out_ready,
	output cbez_pkg::coord_t res [cbez_pkg::NUM_OUTS]
);

	localparam int UB = cbez_pkg::U_BITS;
	localparam int SB = cbez_pkg::SQ_BITS;
	localparam int CB = cbez_pkg::CUBE_BITS;
	localparam int WB = cbez_pkg::W_BITS;
	localparam int PB = cbez_pkg::PROD_BITS;
	localparam int SUMB = cbez_pkg::SUM_BITS;
	localparam int RB = cbez_pkg::RQ_BITS;
	localparam int NO = cbez_pkg::NUM_OUTS;
	localparam int NA = cbez_pkg::NUM_AXES;
	localparam int XB = CB + 2;
	localparam int NST = 7;
	localparam logic [XB-1:0] RND_W = XB'(1) << 15;
	localparam logic signed [SUMB-1:0] RND_S = SUMB'(1) << 31;
	localparam logic signed [RB-1:0] SAT_HI = RB'((1 << (cbez_pkg::COORD_BITS - 1)) - 1);
	localparam logic signed [RB-1:0] SAT_LO = -SAT_HI - RB'(1);

	logic                      vld_q [NST];
	logic                      adv;

	logic [UB-1:0]             u_s1, v_s1;
	logic [UB-1:0]             u_s2, v_s2;
	logic [SB-1:0]             uu_s2, vv_s2;
	logic [CB-1:0]             p_s3 [4];
	logic [WB-1:0]             w_s4 [4];
	logic signed [PB-1:0]      m_s5 [NO][4];
	logic signed [SUMB-1:0]    sum_s6 [NO];
	cbez_pkg::coord_t          res_s7 [NO];

	logic [XB-1:0]             px [4];
	logic [XB-1:0]             wx [4];
	logic signed [RB-1:0]      rq [NO];

	always_comb begin
		adv = !vld_q[NST-1] || out_ready;
		in_ready = adv;
		out_valid = vld_q[NST-1];
		for (int o = 0; o < NO; o++)
			res[o] = res_s7[o];
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			px[i] = {2'b00, p_s3[i]};
			if (i == 1 || i == 2)
				px[i] = (px[i] << 1) + px[i];
			wx[i] = (px[i] + RND_W) >> 16;
		end
		for (int o = 0; o < NO; o++)
			rq[o] = sum_s6[o][SUMB-1:cbez_pkg::FRAC_DROP];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++)
				vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < NST; k++)
				vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1 <= u;
			v_s1 <= cbez_pkg::U_ONE - u;

			u_s2 <= u_s1;
			v_s2 <= v_s1;
			uu_s2 <= SB'(u_s1) * SB'(u_s1);
			vv_s2 <= SB'(v_s1) * SB'(v_s1);

			p_s3[0] <= CB'(vv_s2) * CB'(v_s2);
			p_s3[1] <= CB'(vv_s2) * CB'(u_s2);
			p_s3[2] <= CB'(uu_s2) * CB'(v_s2);
			p_s3[3] <= CB'(uu_s2) * CB'(u_s2);

			for (int i = 0; i < 4; i++)
				w_s4[i] <= wx[i][WB-1:0];

			for (int g = 0; g < 2; g++)
				for (int a = 0; a < NA; a++)
					for (int i = 0; i < 4; i++)
						m_s5[g*NA+a][i] <= PB'(signed'({1'b0, w_s4[i]}))
							* PB'(cbez_pkg::coord_of(ctrl[g*4+i], a));

			for (int o = 0; o < NO; o++)
				sum_s6[o] <= SUMB'(m_s5[o][0]) + SUMB'(m_s5[o][1])
					+ SUMB'(m_s5[o][2]) + SUMB'(m_s5[o][3]) + RND_S;

			for (int o = 0; o < NO; o++) begin
				if (rq[o] > SAT_HI)
					res_s7[o] <= cbez_pkg::coord_t'(SAT_HI);
				else if (rq[o] < SAT_LO)
					res_s7[o] <= cbez_pkg::coord_t'(SAT_LO);
				else
					res_s7[o] <= cbez_pkg::coord_t'(rq[o]);
			end
		end
	end

endmodule

>>> hw/rtl/cubic_bezier_point_eval_top.sv
// Cubic Bezier evaluator: each item (elapsed, span) gives u = elapsed/span in unsigned Q1.16,
// forced to 1 when span is zero or elapsed reaches span, and returns the position and
// direction curves at u, each coordinate signed Q10.10, rounded and saturated. Control points
// are written through cfg_we/cfg_index/cfg_data (x in bits 19:0, y in 39:20, z in 59:40);
// indexes past 7 are ignored. One item is accepted per clock at full rate while out_ready
// stays high. Items pass through the bit-per-stage divider, the queue between divider and
// arithmetic, and the weight multipliers, blend products, sum and saturation.
module cubic_bezier_point_eval_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cbez_pkg::IDX_BITS-1:0]        cfg_index,
	input  logic [cbez_pkg::REG_BITS-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [cbez_pkg::TIME_BITS-1:0]       elapsed,
	input  logic [cbez_pkg::TIME_BITS-1:0]       span,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output cbez_pkg::coord_t                     pos_x,
	output cbez_pkg::coord_t                     pos_y,
	output cbez_pkg::coord_t                     pos_z,
	output cbez_pkg::coord_t                     dir_x,
	output cbez_pkg::coord_t                     dir_y,
	output cbez_pkg::coord_t                     dir_z
);

	cbez_pkg::reg_t   ctrl_q [cbez_pkg::NUM_REGS];
	cbez_pkg::coord_t res [cbez_pkg::NUM_OUTS];
	cbez_pkg::u_t     f_u;
	cbez_pkg::u_t     q_u;
	logic             f_valid, f_ready;
	logic             q_valid, q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cbez_pkg::NUM_REGS; i++)
				ctrl_q[i] <= '0;
		end else if (cfg_we && (cfg_index < cbez_pkg::IDX_BITS'(cbez_pkg::NUM_REGS))) begin
			ctrl_q[cfg_index[cbez_pkg::SEL_BITS-1:0]] <= cfg_data;
		end
	end

	cbez_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.elapsed   (elapsed),
		.span      (span),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.u         (f_u)
	);

	cbez_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_u     (f_u),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_u      (q_u)
	);

	cbez_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.u         (q_u),
		.ctrl      (ctrl_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign pos_x = res[0];
	assign pos_y = res[1];
	assign pos_z = res[2];
	assign dir_x = res[3];
	assign dir_y = res[4];
	assign dir_z = res[5];

endmodule
